// ===== hdl/nbc_pkg.sv =====
// Package for the neighbor contrast (beta) estimator.
// Holds sizes, the sequencer state type and shared constants.
// Depends on nothing.
package nbc_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int CHAN_W    = 8;
    localparam int PIX_W     = 3 * CHAN_W;
    localparam int DIST_W    = 18;
    localparam int WIDTH_W   = 12;
    localparam int SUM_W     = 42;
    localparam int CNT_W     = 25;
    localparam int BETA_W    = 56;
    localparam int BETA_SHIFT = 31;
    localparam int DIV_STEPS = BETA_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(MAX_WIDTH);
    localparam logic [WIDTH_W-1:0] WIDTH_MAX   = WIDTH_W'(MAX_WIDTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEFT,
        ST_UP,
        ST_UPLEFT,
        ST_UPRIGHT,
        ST_LAUNCH,
        ST_DIVIDE
    } nbc_state_t;

endpackage

// ===== hdl/nbc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module nbc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/nbc_sqdist.sv =====
// Squared color distance of one pixel pair: sum of three squared signed
// channel differences. Depends on nbc_pkg.
module nbc_sqdist (
    input  logic [nbc_pkg::PIX_W-1:0]  pix_a,
    input  logic [nbc_pkg::PIX_W-1:0]  pix_b,
    output logic [nbc_pkg::DIST_W-1:0] pair_sq
);

    localparam int DW = nbc_pkg::CHAN_W + 1;

    logic signed [DW-1:0]   diff [3];
    logic signed [2*DW-1:0] sq   [3];

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            diff[ch] = $signed({1'b0, pix_a[ch*nbc_pkg::CHAN_W +: nbc_pkg::CHAN_W]})
                     - $signed({1'b0, pix_b[ch*nbc_pkg::CHAN_W +: nbc_pkg::CHAN_W]});
            sq[ch]   = diff[ch] * diff[ch];
        end
        pair_sq = nbc_pkg::DIST_W'($unsigned(sq[0]))
                + nbc_pkg::DIST_W'($unsigned(sq[1]))
                + nbc_pkg::DIST_W'($unsigned(sq[2]));
    end

endmodule

// ===== hdl/nbc_divider.sv =====
// Restoring divider, one quotient bit per cycle; quotient holds until next start.
// Depends on nbc_pkg.
module nbc_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [nbc_pkg::BETA_W-1:0]  dividend,
    input  logic [nbc_pkg::SUM_W-1:0]   divisor,
    output logic                        done,
    output logic [nbc_pkg::BETA_W-1:0]  quotient
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [nbc_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [nbc_pkg::SUM_W-1:0]      rem_reg, rem_next;
    logic [nbc_pkg::SUM_W-1:0]      dvs_reg, dvs_next;
    logic [nbc_pkg::BETA_W-1:0]     quo_reg, quo_next;
    logic [nbc_pkg::SUM_W:0]        trial;
    logic [nbc_pkg::SUM_W:0]        diff;
    logic                           fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[nbc_pkg::BETA_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = trial >= {1'b0, dvs_reg};

        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;

        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = nbc_pkg::DIV_CNT_W'(nbc_pkg::DIV_STEPS - 1);
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[nbc_pkg::SUM_W-1:0] : trial[nbc_pkg::SUM_W-1:0];
            quo_next = {quo_reg[nbc_pkg::BETA_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/neighbor_contrast_beta.sv =====
// Top level of the neighbor contrast (beta) estimator.
// Depends on nbc_pkg, nbc_ram, nbc_sqdist and nbc_divider.
//
// Usage:
//  - Input channel (in_valid / in_stall): one BGR pixel per transaction in raster
//    order; is_last marks the final pixel of the frame. in_stall is low only in
//    the idle state.
//  - Output channel (out_valid / out_stall): one transaction per frame, issued for
//    the is_last pixel: beta_fixed = floor(count * 2^31 / sum) (Q25.31), the pair
//    count, the squared sum and a zero-contrast flag.
//  - cfg_we / cfg_wdata write image_width (reset 2048); write only while idle.
//  - Per pixel: no new pixel is taken until the current one is through. One read
//    of the line store per neighbor row access (up, then up-right) on its single
//    read port; one pair per cycle through a shared squared-distance unit (left,
//    up, up-left, up-right), the left pair while up-right is read. The result comes
//    from the bit-serial divider (56 steps), skipped when sum or count is zero.
//  - A waiting result sits in the output register; new pixels are taken meanwhile.
//    A following frame end stalls the input until that register is free.
//  - Reset clears the frame state and sets width to 2048; line store contents stay
//    undefined, need no clearing pass. Sum and count clear when a result is loaded.
module neighbor_contrast_beta (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_we,
    input  logic [nbc_pkg::WIDTH_W-1:0]   cfg_wdata,
    // pixel input
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [nbc_pkg::CHAN_W-1:0]    pixel_blue,
    input  logic [nbc_pkg::CHAN_W-1:0]    pixel_green,
    input  logic [nbc_pkg::CHAN_W-1:0]    pixel_red,
    input  logic                          is_last,
    // result output
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [nbc_pkg::BETA_W-1:0]    beta_fixed,
    output logic [nbc_pkg::CNT_W-1:0]     pair_count,
    output logic [nbc_pkg::SUM_W-1:0]     squared_sum,
    output logic                          zero_contrast
);

    localparam int COL_W = nbc_pkg::COL_W;
    localparam int PIX_W = nbc_pkg::PIX_W;

    nbc_pkg::nbc_state_t state_reg, state_next;

    // config
    logic [nbc_pkg::WIDTH_W-1:0] width_reg;
    logic [nbc_pkg::WIDTH_W-1:0] width_eff;

    // frame state
    logic [COL_W-1:0]          col_reg, col_next;
    logic                      first_reg, first_next;
    logic [PIX_W-1:0]          left_reg, left_next;
    logic [PIX_W-1:0]          upleft_reg, upleft_next;
    logic [nbc_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [nbc_pkg::CNT_W-1:0] count_reg, count_next;

    // current transaction
    logic [PIX_W-1:0] cur_reg;
    logic             last_reg;
    logic [PIX_W-1:0] up_reg;
    logic [PIX_W-1:0] ur_reg;

    // result register
    logic                          out_valid_reg, out_valid_next;
    logic [nbc_pkg::BETA_W-1:0]    beta_reg;
    logic [nbc_pkg::CNT_W-1:0]     count_out_reg;
    logic [nbc_pkg::SUM_W-1:0]     sum_out_reg;
    logic                          zc_out_reg;

    // control / datapath
    logic                   accept;
    logic                   has_left;
    logic                   last_col;
    logic                   zc;
    logic                   out_free;
    logic                   rd_en;
    logic [COL_W-1:0]       rd_addr;
    logic [PIX_W-1:0]       rd_data;
    logic                   wr_en;
    logic                   pair_en;
    logic [PIX_W-1:0]       nb_pix;
    logic [nbc_pkg::DIST_W-1:0] pair_sq;
    logic [nbc_pkg::SUM_W:0]    sum_ext;
    logic                   div_start;
    logic                   div_done;
    logic [nbc_pkg::BETA_W-1:0] quotient;
    logic                   result_load;
    logic [nbc_pkg::BETA_W-1:0] beta_val;

    // width 0 acts as 1, above the line store depth acts as the depth
    always_comb
    begin
        if (width_reg == '0)
            width_eff = nbc_pkg::WIDTH_W'(1);
        else if (width_reg > nbc_pkg::WIDTH_MAX)
            width_eff = nbc_pkg::WIDTH_MAX;
        else
            width_eff = width_reg;
    end

    assign has_left = col_reg != '0;
    assign last_col = (nbc_pkg::WIDTH_W'(col_reg) + 1'b1) >= width_eff;
    assign zc       = (sum_reg == '0) || (count_reg == '0);
    assign out_free = !out_valid_reg || !out_stall;
    assign accept   = in_valid && !in_stall;

    // line store: previous row of pixels
    nbc_ram #(
        .WIDTH (PIX_W),
        .DEPTH (nbc_pkg::MAX_WIDTH)
    ) u_row_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (col_reg),
        .wr_data (cur_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    nbc_sqdist u_sqdist (
        .pix_a   (cur_reg),
        .pix_b   (nb_pix),
        .pair_sq (pair_sq)
    );

    nbc_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({count_reg, nbc_pkg::BETA_SHIFT'(0)}),
        .divisor  (sum_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nbc_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = nbc_pkg::ST_LEFT;
            end
            nbc_pkg::ST_LEFT:    state_next = nbc_pkg::ST_UP;
            nbc_pkg::ST_UP:      state_next = nbc_pkg::ST_UPLEFT;
            nbc_pkg::ST_UPLEFT:  state_next = nbc_pkg::ST_UPRIGHT;
            nbc_pkg::ST_UPRIGHT:
            begin
                state_next = last_reg ? nbc_pkg::ST_LAUNCH : nbc_pkg::ST_IDLE;
            end
            nbc_pkg::ST_LAUNCH:  state_next = nbc_pkg::ST_DIVIDE;
            nbc_pkg::ST_DIVIDE:
            begin
                if ((zc || div_done) && out_free)
                    state_next = nbc_pkg::ST_IDLE;
            end
            default:             state_next = nbc_pkg::ST_IDLE;
        endcase
    end

    // state outputs: memory access, pair select, divider launch
    always_comb
    begin
        in_stall    = 1'b1;
        rd_en       = 1'b0;
        rd_addr     = col_reg;
        wr_en       = 1'b0;
        pair_en     = 1'b0;
        nb_pix      = left_reg;
        div_start   = 1'b0;
        result_load = 1'b0;
        unique case (state_reg)
            nbc_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                rd_en    = in_valid;
            end
            nbc_pkg::ST_LEFT:
            begin
                // fetch up-right while the left pair accumulates
                rd_en   = 1'b1;
                rd_addr = col_reg + 1'b1;
                pair_en = has_left;
                nb_pix  = left_reg;
            end
            nbc_pkg::ST_UP:
            begin
                // both reads are done: overwrite this column with the new pixel
                wr_en   = 1'b1;
                pair_en = !first_reg;
                nb_pix  = up_reg;
            end
            nbc_pkg::ST_UPLEFT:
            begin
                pair_en = !first_reg && has_left;
                nb_pix  = upleft_reg;
            end
            nbc_pkg::ST_UPRIGHT:
            begin
                pair_en = !first_reg && !last_col;
                nb_pix  = ur_reg;
            end
            nbc_pkg::ST_LAUNCH:
            begin
                div_start = !zc;
            end
            nbc_pkg::ST_DIVIDE:
            begin
                result_load = (zc || div_done) && out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // beta: zero without pairs, saturated with pairs but zero sum
    always_comb
    begin
        if (count_reg == '0)
            beta_val = '0;
        else if (sum_reg == '0)
            beta_val = '1;
        else
            beta_val = quotient;
    end

    // frame state update
    always_comb
    begin
        col_next    = col_reg;
        first_next  = first_reg;
        left_next   = left_reg;
        upleft_next = upleft_reg;
        sum_next    = sum_reg;
        count_next  = count_reg;

        sum_ext = {1'b0, sum_reg} + (nbc_pkg::SUM_W + 1)'(pair_sq);

        if (pair_en)
        begin
            sum_next = sum_ext[nbc_pkg::SUM_W] ? '1 : sum_ext[nbc_pkg::SUM_W-1:0];
            if (count_reg != '1)
                count_next = count_reg + 1'b1;
        end

        if (state_reg == nbc_pkg::ST_UPRIGHT)
        begin
            if (last_col || last_reg)
            begin
                col_next    = '0;
                left_next   = '0;
                upleft_next = '0;
                first_next  = last_reg ? 1'b1 : 1'b0;
            end
            else
            begin
                col_next    = col_reg + 1'b1;
                left_next   = cur_reg;
                upleft_next = up_reg;
            end
        end

        if (result_load)
        begin
            sum_next   = '0;
            count_next = '0;
        end

        out_valid_next = out_valid_reg;
        if (result_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nbc_pkg::ST_IDLE;
            width_reg     <= nbc_pkg::WIDTH_RESET;
            col_reg       <= '0;
            first_reg     <= 1'b1;
            left_reg      <= '0;
            upleft_reg    <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            first_reg     <= first_next;
            left_reg      <= left_next;
            upleft_reg    <= upleft_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                width_reg <= cfg_wdata;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg  <= {pixel_red, pixel_green, pixel_blue};
            last_reg <= is_last;
        end
        if (state_reg == nbc_pkg::ST_LEFT)
            up_reg <= rd_data;
        if (state_reg == nbc_pkg::ST_UP)
            ur_reg <= rd_data;
        if (result_load)
        begin
            beta_reg      <= beta_val;
            count_out_reg <= count_reg;
            sum_out_reg   <= sum_reg;
            zc_out_reg    <= zc;
        end
    end

    assign out_valid     = out_valid_reg;
    assign beta_fixed    = beta_reg;
    assign pair_count    = count_out_reg;
    assign squared_sum   = sum_out_reg;
    assign zero_contrast = zc_out_reg;

endmodule
